### rtl/core/periodic_task_tick_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define PTTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/core/ptts_pkg.sv
// Package for the periodic task tick scheduler: payload structs, codes,
// sequencer states and the modulo unit interface. Depends on nothing.
`default_nettype none

package ptts_pkg;

  localparam logic [7:0] INVALID_ID = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_STOP     = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } ptts_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_START = 2'd2,
    ST_HOLD     = 2'd3
  } ptts_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_DONE
  } ptts_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic        one_shot;
  } ptts_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [2:0] fired_slot;
    logic [7:0] fired_id;
    logic       last;
  } ptts_out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic        one_shot;
  } ptts_slot_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } ptts_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } ptts_div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/ptts_mod.sv
// Iterative restoring remainder unit: 32-bit dividend modulo 16-bit divisor,
// one quotient bit per cycle. Depends on ptts_pkg.
`default_nettype none

module ptts_mod (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ptts_pkg::ptts_div_req_t req,
  output ptts_pkg::ptts_div_rsp_t      rsp
);
  import ptts_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = 16'h0;
    end else if (busy_r) begin
      // subtract when the trial remainder covers the divisor, else restore
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[15:0] : trial[15:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

### rtl/core/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler: task table memory, scan
// sequencer and result register. Depends on ptts_pkg, ptts_mod and the defines.
`default_nettype none

// A transaction is taken at a rising edge with start high and busy low; every
// result shows on out_data for exactly one cycle with out_valid high, and the
// receiver cannot stall it, so sample out_data whenever out_valid is set.
// Add, tick, a dispatch with no tick pending, and a stop or dispatch on an
// empty table leave busy low: the result appears the cycle after the
// transaction. Otherwise a stop scans the added slots through the table
// memory's single registered read port, reading each slot in S_READ and
// checking it in S_EVAL, until it finds the identifier. A dispatch with a tick
// pending scans the added slots the same way, runs the shared bit-serial
// modulo unit in S_DIV for each valid slot with a nonzero period, and closes
// in S_DONE. Fired tasks come out in slot order, one result per fired slot;
// the last flag marks the final result of each transaction. The table needs
// no clearing after reset: only slots below the fill count are ever read.

`include "periodic_task_tick_scheduler_defines.svh"

module periodic_task_tick_scheduler #(
  parameter int SLOTS = 8
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire ptts_pkg::ptts_in_t in_data,
  output logic                    out_valid,
  output ptts_pkg::ptts_out_t     out_data
);
  import ptts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  ptts_state_t   state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [31:0]   tick_r, tick_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    tid_r, tid_nxt;
  logic          prev_vld_r, prev_vld_nxt;
  logic [IW-1:0] prev_slot_r, prev_slot_nxt;
  logic [7:0]    prev_id_r, prev_id_nxt;
  logic          out_valid_r, out_valid_nxt;
  ptts_out_t     out_r, out_nxt;

  // table memory, one write and one registered read port
  ptts_slot_t    mem [SLOTS];
  ptts_slot_t    rd_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ptts_slot_t    wr_data;

  ptts_div_req_t div_req;
  ptts_div_rsp_t div_rsp;

  logic accept;
  logic last_slot;
  logic cand;
  logic fin;
  logic fire_now;

  ptts_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx_r];
  end

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign last_slot = (CW'(idx_r) == used_r - CW'(1));
  // a slot is worth a modulo only when it is live and its period is nonzero
  assign cand      = (rd_q.id != INVALID_ID) && (rd_q.period != 16'h0);
  assign fin       = ((state_r == S_EVAL) && (op_r == OP_DISPATCH) && !cand) ||
                     ((state_r == S_DIV) && div_rsp.done);
  assign fire_now  = (state_r == S_DIV) && (div_rsp.rem == 16'h0);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    tick_nxt      = tick_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    tid_nxt       = tid_r;
    prev_vld_nxt  = prev_vld_r;
    prev_slot_nxt = prev_slot_r;
    prev_id_nxt   = prev_id_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '{status: ST_OK, fired: 1'b0, fired_slot: 3'd0,
                      fired_id: 8'h0, last: 1'b1};
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '{id: INVALID_ID, period: rd_q.period, one_shot: rd_q.one_shot};
    div_req       = '{start: 1'b0, dividend: tick_r, divisor: rd_q.period};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_data.op;
          tid_nxt      = in_data.task_id;
          idx_nxt      = '0;
          prev_vld_nxt = 1'b0;
          unique case (ptts_op_t'(in_data.op))
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (used_r == CW'(SLOTS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                // append at the fill count
                wr_en    = 1'b1;
                wr_addr  = IW'(used_r);
                wr_data  = '{id: in_data.task_id, period: in_data.period,
                             one_shot: in_data.one_shot};
                used_nxt = used_r + CW'(1);
              end
            end
            OP_STOP: begin
              if (used_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_NO_START;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_TICK: begin
              out_valid_nxt = 1'b1;
              tick_nxt      = tick_r + 32'd1;
              pend_nxt      = 1'b1;
            end
            OP_DISPATCH: begin
              if (!pend_r) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_HOLD;
              end else if (used_r == '0) begin
                out_valid_nxt = 1'b1;
                pend_nxt      = 1'b0;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        // wait for the registered read of slot idx_r
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (op_r == OP_STOP) begin
          if (rd_q.id == tid_r) begin
            wr_en         = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (last_slot) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_NO_START;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_READ;
          end
        end else if (cand) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end

      S_DIV: begin
        // hold until the modulo unit reports
      end

      S_DONE: begin
        // flush the held firing with last set, or report an empty dispatch
        out_valid_nxt = 1'b1;
        pend_nxt      = 1'b0;
        state_nxt     = S_IDLE;
        if (prev_vld_r) begin
          out_nxt.fired      = 1'b1;
          out_nxt.fired_slot = 3'(prev_slot_r);
          out_nxt.fired_id   = prev_id_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      // drop one-shot slots whose period has been reached, stopped or not
      if (rd_q.one_shot && ({16'h0, rd_q.period} == tick_r)) begin
        wr_en = 1'b1;
      end
      // hold each firing one slot back so the final one can carry last
      if (fire_now) begin
        if (prev_vld_r) begin
          out_valid_nxt      = 1'b1;
          out_nxt.fired      = 1'b1;
          out_nxt.fired_slot = 3'(prev_slot_r);
          out_nxt.fired_id   = prev_id_r;
          out_nxt.last       = 1'b0;
        end
        prev_vld_nxt  = 1'b1;
        prev_slot_nxt = idx_r;
        prev_id_nxt   = rd_q.id;
      end
      if (last_slot) begin
        state_nxt = S_DONE;
      end else begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      tick_r      <= 32'd0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      tick_r      <= tick_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    tid_r       <= tid_nxt;
    prev_slot_r <= prev_slot_nxt;
    prev_id_r   <= prev_id_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PTTS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, used_r <= CW'(SLOTS))
  `PTTS_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == S_EVAL, CW'(idx_r) < used_r)
  `PTTS_ASSERT_IMP(a_div_needs_tick, clk, rst_n, state_r == S_DIV, pend_r && op_r == OP_DISPATCH)
  `PTTS_ASSERT_NXT(a_add_no_busy, clk, rst_n, accept && in_data.op == OP_ADD, !busy && out_valid)

endmodule

`default_nettype wire

### sim/ptts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the periodic task tick scheduler: watches both channels,
// predicts every result from its own copy of the task table and compares.
// Depends on ptts_pkg for the payload structs and the op and status codes.

module ptts_checker #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ptts_pkg::ptts_in_t  in_data,
  input  logic                out_valid,
  input  ptts_pkg::ptts_out_t out_data,
  output int                  mismatch_count,
  output int                  results_due,
  output int                  fired_seen
);
  import ptts_pkg::*;

  // Task table as the scheduler should hold it.
  logic [7:0]  tbl_id     [SLOTS];
  logic [15:0] tbl_period [SLOTS];
  logic        tbl_once   [SLOTS];
  int unsigned tbl_fill;
  logic [31:0] tick_cnt;
  logic        tick_armed;

  // Results still owed by the block, oldest first.
  ptts_out_t   due_results[$];
  ptts_out_t   want;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    fired_seen     = 0;
  end

  function automatic ptts_out_t pack_result(ptts_status_t st, logic fired,
                                            logic [2:0] slot, logic [7:0] id,
                                            logic last);
    ptts_out_t r;
    r.status     = st;
    r.fired      = fired;
    r.fired_slot = slot;
    r.fired_id   = id;
    r.last       = last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("ptts_checker: mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Advance the table by one transaction and queue what it must produce.
  task automatic schedule_apply(input ptts_in_t t);
    ptts_status_t st;
    logic         found;
    int unsigned  n;
    logic [15:0]  p;
    logic [2:0]   hit_slot [SLOTS];
    logic [7:0]   hit_id   [SLOTS];
    st    = ST_OK;
    found = 1'b0;
    n     = 0;
    case (t.op)
      OP_ADD: begin
        if (tbl_fill >= SLOTS) begin
          st = ST_FULL;
        end else begin
          tbl_id[tbl_fill]     = t.task_id;
          tbl_period[tbl_fill] = t.period;
          tbl_once[tbl_fill]   = t.one_shot;
          tbl_fill++;
        end
        due_results.push_back(pack_result(st, 1'b0, 3'd0, 8'd0, 1'b1));
      end
      OP_STOP: begin
        // First added slot with a matching id wins, invalid ones included.
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && i < tbl_fill && tbl_id[i] == t.task_id) begin
            tbl_id[i] = INVALID_ID;
            found     = 1'b1;
          end
        end
        st = found ? ST_OK : ST_NO_START;
        due_results.push_back(pack_result(st, 1'b0, 3'd0, 8'd0, 1'b1));
      end
      OP_TICK: begin
        tick_cnt   = tick_cnt + 32'd1;
        tick_armed = 1'b1;
        due_results.push_back(pack_result(ST_OK, 1'b0, 3'd0, 8'd0, 1'b1));
      end
      default: begin
        if (!tick_armed) begin
          due_results.push_back(pack_result(ST_HOLD, 1'b0, 3'd0, 8'd0, 1'b1));
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (i < tbl_fill) begin
              p = tbl_period[i];
              if (tbl_id[i] != INVALID_ID && p != 16'd0 &&
                  (tick_cnt % {16'd0, p}) == 32'd0) begin
                hit_slot[n] = i[2:0];
                hit_id[n]   = tbl_id[i];
                n++;
              end
              // Expire one-shots on an exact period match, even stopped ones.
              if (tbl_once[i] && {16'd0, p} == tick_cnt) tbl_id[i] = INVALID_ID;
            end
          end
          tick_armed = 1'b0;
          if (n == 0) begin
            due_results.push_back(pack_result(ST_OK, 1'b0, 3'd0, 8'd0, 1'b1));
          end else begin
            for (int k = 0; k < n; k++) begin
              due_results.push_back(pack_result(ST_OK, 1'b1, hit_slot[k], hit_id[k],
                                                k == n - 1));
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_id[i]     = 8'd0;
        tbl_period[i] = 16'd0;
        tbl_once[i]   = 1'b0;
      end
      tbl_fill   = 0;
      tick_cnt   = 32'd0;
      tick_armed = 1'b0;
      due_results.delete();
    end else begin
      // Retire the result first: it always belongs to an earlier transaction.
      if (out_valid) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_data.status,
                                      want.status));
          if (out_data.fired !== want.fired)
            report_mismatch($sformatf("fired %0b, want %0b", out_data.fired,
                                      want.fired));
          if (out_data.fired_slot !== want.fired_slot)
            report_mismatch($sformatf("fired_slot %0d, want %0d",
                                      out_data.fired_slot, want.fired_slot));
          if (out_data.fired_id !== want.fired_id)
            report_mismatch($sformatf("fired_id %h, want %h", out_data.fired_id,
                                      want.fired_id));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_data.last,
                                      want.last));
          if (want.fired) fired_seen++;
        end
      end
      if (start && !busy) schedule_apply(in_data);
    end
    results_due = due_results.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, directed and random command
// stimulus, and the verdict. Depends on ptts_pkg, ptts_checker and the RTL.

module tb_top;
  import ptts_pkg::*;

  localparam int SLOTS = 8;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  ptts_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  ptts_out_t out_data;

  int mismatch_count;
  int results_due;
  int fired_seen;

  // Percentage of cycles in which the sender holds start low before a transaction.
  int idle_pct = 0;
  int sent     = 0;
  int op_seen [4];

  ptts_in_t  item;
  int        pick;
  logic [7:0] stop_id;

  // 4 ns period.
  always #2 clk = ~clk;

  periodic_task_tick_scheduler #(
    .SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // The checker sits beside the block and owns all prediction and comparison.
  ptts_checker #(
    .SLOTS(SLOTS)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .results_due   (results_due),
    .fired_seen    (fired_seen)
  );

  // Hard stop: several times the slowest legal run (every dispatch taking its
  // full scan of eight slots plus sender gaps).
  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic ptts_in_t mk_item(ptts_op_t op, logic [7:0] id, logic [15:0] p,
                                       logic once);
    ptts_in_t t;
    t.op       = op;
    t.task_id  = id;
    t.period   = p;
    t.one_shot = once;
    return t;
  endfunction

  // Present one transaction from the falling edge and hold it until the block
  // takes it. Busy is read at the rising edge, before the block updates it.
  task automatic send_item(input ptts_in_t t);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = t;
    op_seen[t.op]++;
    sent++;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) op_seen[i] = 0;

    // Hold reset, then release it on a falling edge.
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- Directed part ----
    // Dispatch before any tick: hold.
    send_item(mk_item(OP_DISPATCH, 8'h00, 16'h0000, 1'b0));
    // Tick, then dispatch over an empty table: success with nothing fired.
    send_item(mk_item(OP_TICK, 8'hFF, 16'hFFFF, 1'b1));
    send_item(mk_item(OP_DISPATCH, 8'hFF, 16'hFFFF, 1'b1));
    // Stop on an empty table: not started.
    send_item(mk_item(OP_STOP, 8'h42, 16'h0000, 1'b0));
    // Fill all eight slots: every-tick task, task added invalid, one-shot with
    // period zero, one-shot at period two, periods three, max, five and four.
    send_item(mk_item(OP_ADD, 8'h11, 16'd1, 1'b0));
    send_item(mk_item(OP_ADD, 8'hFF, 16'd1, 1'b0));
    send_item(mk_item(OP_ADD, 8'h00, 16'd0, 1'b1));
    send_item(mk_item(OP_ADD, 8'hA5, 16'd2, 1'b1));
    send_item(mk_item(OP_ADD, 8'h5A, 16'd3, 1'b0));
    send_item(mk_item(OP_ADD, 8'h7E, 16'hFFFF, 1'b0));
    send_item(mk_item(OP_ADD, 8'h33, 16'd5, 1'b0));
    send_item(mk_item(OP_ADD, 8'hC3, 16'd4, 1'b0));
    // One more add: table full.
    send_item(mk_item(OP_ADD, 8'h99, 16'd7, 1'b1));
    // Pending flag already cleared: hold again.
    send_item(mk_item(OP_DISPATCH, 8'h00, 16'h0000, 1'b0));
    // Count two: the every-tick task fires and the one-shot fires and expires.
    send_item(mk_item(OP_TICK, 8'h00, 16'h0000, 1'b0));
    send_item(mk_item(OP_DISPATCH, 8'h00, 16'h0000, 1'b0));
    // Stop a live id, then the same id again, then the invalid id itself.
    send_item(mk_item(OP_STOP, 8'h33, 16'h0000, 1'b0));
    send_item(mk_item(OP_STOP, 8'h33, 16'h0000, 1'b0));
    send_item(mk_item(OP_STOP, 8'hFF, 16'h0000, 1'b0));
    // Two ticks before one dispatch: only count four is handled.
    send_item(mk_item(OP_TICK, 8'h00, 16'h0000, 1'b0));
    send_item(mk_item(OP_TICK, 8'h00, 16'h0000, 1'b0));
    send_item(mk_item(OP_DISPATCH, 8'h00, 16'h0000, 1'b0));
    // The expired one-shot can no longer be stopped.
    send_item(mk_item(OP_STOP, 8'hA5, 16'h0000, 1'b0));

    // ---- Random part ----
    // Mostly ticks and dispatches so the table keeps firing; stops usually miss
    // or hit dead ids, and only rarely kill a live periodic task.
    for (int k = 0; k < 410; k++) begin
      // Sender idling phases: none, heavy, none, light.
      case (k * 4 / 410)
        0:       idle_pct = 0;
        1:       idle_pct = 53;
        2:       idle_pct = 0;
        default: idle_pct = 12;
      endcase

      item.task_id  = 8'($urandom_range(0, 255));
      item.period   = 16'($urandom_range(0, 65535));
      item.one_shot = 1'($urandom_range(0, 1));
      pick = $urandom_range(99);
      if (pick < 10) begin
        item.op = OP_ADD;
      end else if (pick < 25) begin
        item.op = OP_STOP;
        stop_id = item.task_id;
        case ($urandom_range(99)) inside
          [0:59]:  stop_id = item.task_id;
          [60:84]: stop_id = INVALID_ID;
          [85:96]: stop_id = $urandom_range(1) ? 8'hA5 : 8'h33;
          default: stop_id = $urandom_range(1) ? 8'h5A : 8'hC3;
        endcase
        item.task_id = stop_id;
      end else if (pick < 60) begin
        item.op = OP_TICK;
      end else begin
        item.op = OP_DISPATCH;
      end
      send_item(item);
    end

    // Drop start and drain everything still owed.
    start    = 1'b0;
    idle_pct = 0;
    while (results_due != 0) @(negedge clk);
    // Give the block a full dispatch scan to show any stray result.
    repeat (300) @(negedge clk);

    $display("summary: %0d transactions (add %0d, stop %0d, tick %0d, dispatch %0d)",
             sent, op_seen[OP_ADD], op_seen[OP_STOP], op_seen[OP_TICK],
             op_seen[OP_DISPATCH]);
    $display("summary: %0d task firings checked, %0d mismatches", fired_seen,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### periodic_task_tick_scheduler.f
+incdir+rtl/core
rtl/core/ptts_pkg.sv
rtl/core/ptts_mod.sv
rtl/core/periodic_task_tick_scheduler.sv
sim/ptts_checker.sv
sim/tb_top.sv
